>>> src/sar_pkg.sv
// ============================================================================
// sar_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the sprite attribute resolver.
// ============================================================================
package sar_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int SPRITE_COUNT_DEF     = 1024;
    localparam int EXTENDED_ENTRIES_DEF = 16384;

    // Fixed byte-level sizes of the stores.
    localparam int SPRITE_ROW_BYTES = 8;     // bytes per sprite record
    localparam int SPRITE_LANES     = 5;     // bytes of a record that are used
    localparam int OFFSET_ROWS      = 256;   // 4-byte offset entries
    localparam int OFFSET_LANES     = 4;
    localparam int EXT_LANES        = 4;

    // Width of the shared modulo unit's result (holds up to 16383).
    localparam int MOD_W = 14;

    // Request operation codes.
    localparam logic [2:0] OP_WR_SPRITE   = 3'd0;
    localparam logic [2:0] OP_WR_INDEX    = 3'd1;
    localparam logic [2:0] OP_WR_OFFSET   = 3'd2;
    localparam logic [2:0] OP_WR_EXTENDED = 3'd3;
    localparam logic [2:0] OP_RESOLVE     = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_en;      // store the accepted write request
        logic load_addr;  // capture the sprite number of a resolve request
        logic mod_sel;    // modulo unit operand: 0 sprite number, 1 extended pointer
        logic spr_rd;     // read sprite record and index byte
        logic off_rd;     // read offset entry
        logic ext_rd;     // read extended entry
        logic out_load;   // load the result register
    } sar_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_ext;     // offset entry points into the extended table
        logic out_free;   // result register can take a new result
    } sar_status_t;

endpackage

>>> src/sar_mod.sv
// ============================================================================
// sar_mod
// Three-stage constant modulo unit: reciprocal multiply, back-multiply, then
// one compare-and-subtract correction. Shared between the sprite number and
// the extended pointer.
// ============================================================================
module sar_mod #(
    parameter int SPRITE_COUNT     = sar_pkg::SPRITE_COUNT_DEF,
    parameter int EXTENDED_ENTRIES = sar_pkg::EXTENDED_ENTRIES_DEF
) (
    input  logic                      aclk,
    input  logic                      sel,
    input  logic [15:0]               operand,
    output logic [sar_pkg::MOD_W-1:0] result
);

    // Reciprocals scaled by 2^32; the estimate is low by at most one.
    localparam logic [32:0] SPR_RECIP = 33'((64'd1 << 32) / 64'(SPRITE_COUNT));
    localparam logic [32:0] EXT_RECIP = 33'((64'd1 << 32) / 64'(EXTENDED_ENTRIES));
    localparam logic [14:0] SPR_MODULUS = 15'(SPRITE_COUNT);
    localparam logic [14:0] EXT_MODULUS = 15'(EXTENDED_ENTRIES);

    logic [15:0] op1_reg, op2_reg;
    logic        sel1_reg, sel2_reg;
    logic [48:0] prod_reg, prod_next;
    logic [16:0] qc_reg, qc_next;
    logic [30:0] qc_full;
    logic [16:0] diff, modulus3;
    logic [16:0] res_full;
    logic [sar_pkg::MOD_W-1:0] res_reg;

    // Stage 1: quotient estimate.
    assign prod_next = 49'(operand) * 49'(sel ? EXT_RECIP : SPR_RECIP);

    // Stage 2: quotient times modulus, never above the operand.
    assign qc_full = prod_reg[47:32] * (sel1_reg ? EXT_MODULUS : SPR_MODULUS);
    assign qc_next = qc_full[16:0];

    // Stage 3: remainder with a single correction step.
    assign modulus3 = 17'(sel2_reg ? EXT_MODULUS : SPR_MODULUS);
    assign diff     = {1'b0, op2_reg} - qc_reg;
    assign res_full = (diff >= modulus3) ? (diff - modulus3) : diff;

    always_ff @(posedge aclk) begin
        op1_reg  <= operand;
        sel1_reg <= sel;
        prod_reg <= prod_next;
        op2_reg  <= op1_reg;
        sel2_reg <= sel1_reg;
        qc_reg   <= qc_next;
        res_reg  <= res_full[sar_pkg::MOD_W-1:0];
    end

    assign result = res_reg;

endmodule

>>> src/sar_ctrl.sv
// ============================================================================
// sar_ctrl
// Controller for the sprite attribute resolver. Accepts requests, sequences
// the modulo unit and the dependent memory reads of a resolve, and loads the
// result register.
// ============================================================================
module sar_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [2:0]           s_op,
    output logic                 s_ready,
    input  sar_pkg::sar_status_t status,
    output sar_pkg::sar_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SMOD   = 3'd1;
    localparam logic [2:0] ST_RD_SPR = 3'd2;
    localparam logic [2:0] ST_RD_OFF = 3'd3;
    localparam logic [2:0] ST_CHK    = 3'd4;
    localparam logic [2:0] ST_EMOD   = 3'd5;
    localparam logic [2:0] ST_RD_EXT = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    // Last value of the modulo wait count; the unit's result is valid in the state that follows.
    localparam logic [1:0] MOD_LAST = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Next state and command decode.
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.wr_en     = accept && (s_op != sar_pkg::OP_RESOLVE);
        cmd.load_addr = accept && (s_op == sar_pkg::OP_RESOLVE);
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (accept && s_op == sar_pkg::OP_RESOLVE) begin
                    state_next = ST_SMOD;
                end
            end
            ST_SMOD: begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == MOD_LAST) begin
                    state_next = ST_RD_SPR;
                end
            end
            ST_RD_SPR: begin
                cmd.spr_rd = 1'b1;
                state_next = ST_RD_OFF;
            end
            ST_RD_OFF: begin
                cmd.off_rd = 1'b1;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                cnt_next = '0;
                if (status.is_ext) begin
                    state_next = ST_EMOD;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_EMOD: begin
                cmd.mod_sel = 1'b1;
                cnt_next    = cnt_reg + 2'd1;
                if (cnt_reg == MOD_LAST) begin
                    state_next = ST_RD_EXT;
                end
            end
            ST_RD_EXT: begin
                cmd.ext_rd = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> src/sar_dp.sv
// ============================================================================
// sar_dp
// Datapath for the sprite attribute resolver: the four byte-lane memories,
// the modulo unit, the position/code arithmetic and the result register.
// ============================================================================
module sar_dp #(
    parameter int SPRITE_COUNT     = sar_pkg::SPRITE_COUNT_DEF,
    parameter int EXTENDED_ENTRIES = sar_pkg::EXTENDED_ENTRIES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [2:0]           s_op,
    input  logic [15:0]          s_address,
    input  logic [7:0]           s_write_byte,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  sar_pkg::sar_cmd_t    cmd,
    output sar_pkg::sar_status_t status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [16:0]          m_tile_code,
    output logic [1:0]           m_palette,
    output logic                 m_mirror_x,
    output logic                 m_mirror_y,
    output logic signed [9:0]    m_screen_x,
    output logic signed [8:0]    m_screen_y
);

    localparam int SPR_AW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
    localparam int EXT_AW = (EXTENDED_ENTRIES > 1) ? $clog2(EXTENDED_ENTRIES) : 1;

    // Byte-lane memories: one lane per used byte of a record.
    logic [7:0] spr_mem [sar_pkg::SPRITE_LANES][SPRITE_COUNT];
    logic [7:0] idx_mem [SPRITE_COUNT];
    logic [7:0] off_mem [sar_pkg::OFFSET_LANES][sar_pkg::OFFSET_ROWS];
    logic [7:0] ext_mem [sar_pkg::EXT_LANES][EXTENDED_ENTRIES];

    logic [7:0] spr_q [sar_pkg::SPRITE_LANES];
    logic [7:0] off_q [sar_pkg::OFFSET_LANES];
    logic [7:0] ext_q [sar_pkg::EXT_LANES];
    logic [7:0] idx_q;

    logic [15:0] addr_reg;
    logic        short_screen_reg;

    logic [sar_pkg::MOD_W-1:0] mod_res;
    logic [15:0]               mod_operand;
    logic [13:0]               ext_ptr;

    logic spr_we, idx_we, off_we, ext_we;
    logic [SPR_AW-1:0] spr_rd_row, spr_wr_row;
    logic [EXT_AW-1:0] ext_rd_row, ext_wr_row;

    // Write decode; writes beyond a store's range are dropped.
    assign spr_wr_row = s_address[3 +: SPR_AW];
    assign ext_wr_row = s_address[2 +: EXT_AW];
    assign spr_we = cmd.wr_en && (s_op == sar_pkg::OP_WR_SPRITE)
                    && (32'(s_address[15:3]) < 32'(SPRITE_COUNT))
                    && (32'(s_address[2:0]) < 32'(sar_pkg::SPRITE_LANES));
    assign idx_we = cmd.wr_en && (s_op == sar_pkg::OP_WR_INDEX)
                    && (32'(s_address) < 32'(SPRITE_COUNT));
    assign off_we = cmd.wr_en && (s_op == sar_pkg::OP_WR_OFFSET)
                    && (s_address[15:10] == 6'd0);
    assign ext_we = cmd.wr_en && (s_op == sar_pkg::OP_WR_EXTENDED)
                    && (32'(s_address[15:2]) < 32'(EXTENDED_ENTRIES));

    // Shared modulo unit: sprite number, then extended pointer.
    assign ext_ptr     = {off_q[2][5:0], off_q[3]};
    assign mod_operand = cmd.mod_sel ? {2'b00, ext_ptr} : addr_reg;

    sar_mod #(
        .SPRITE_COUNT    (SPRITE_COUNT),
        .EXTENDED_ENTRIES(EXTENDED_ENTRIES)
    ) u_mod (
        .aclk   (aclk),
        .sel    (cmd.mod_sel),
        .operand(mod_operand),
        .result (mod_res)
    );

    assign spr_rd_row = mod_res[SPR_AW-1:0];
    assign ext_rd_row = mod_res[EXT_AW-1:0];

    // Sprite record and index table.
    always_ff @(posedge aclk) begin
        for (int l = 0; l < sar_pkg::SPRITE_LANES; l++) begin
            if (spr_we && s_address[2:0] == 3'(l)) begin
                spr_mem[l][spr_wr_row] <= s_write_byte;
            end
            if (cmd.spr_rd) begin
                spr_q[l] <= spr_mem[l][spr_rd_row];
            end
        end
        if (idx_we) begin
            idx_mem[s_address[SPR_AW-1:0]] <= s_write_byte;
        end
        if (cmd.spr_rd) begin
            idx_q <= idx_mem[spr_rd_row];
        end
    end

    // Offset table.
    always_ff @(posedge aclk) begin
        for (int l = 0; l < sar_pkg::OFFSET_LANES; l++) begin
            if (off_we && s_address[1:0] == 2'(l)) begin
                off_mem[l][s_address[9:2]] <= s_write_byte;
            end
            if (cmd.off_rd) begin
                off_q[l] <= off_mem[l][idx_q];
            end
        end
    end

    // Extended offset table.
    always_ff @(posedge aclk) begin
        for (int l = 0; l < sar_pkg::EXT_LANES; l++) begin
            if (ext_we && s_address[1:0] == 2'(l)) begin
                ext_mem[l][ext_wr_row] <= s_write_byte;
            end
            if (cmd.ext_rd) begin
                ext_q[l] <= ext_mem[l][ext_rd_row];
            end
        end
    end

    // Request address capture.
    always_ff @(posedge aclk) begin
        if (cmd.load_addr) begin
            addr_reg <= s_address;
        end
    end

    // Screen-height register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_screen_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            short_screen_reg <= cfg_wr_data;
        end
    end

    // Result arithmetic.
    logic [7:0]  attr;
    logic [8:0]  x9, y9, xo9, yo9, x_low;
    logic [15:0] yo_raw, xo_raw;
    logic [10:0] ysum;
    logic [8:0]  y_fin;
    logic [16:0] code_sum;
    logic [4:0]  code_off;
    logic        flip_x, flip_y, is_ext;

    assign is_ext = off_q[2][7];
    assign attr   = spr_q[1];
    assign x9     = {attr[7], spr_q[0]};
    assign y9     = {attr[6], spr_q[4]};
    assign yo_raw = {ext_q[1], ext_q[0]};
    assign xo_raw = {ext_q[3], ext_q[2]};

    always_comb begin
        if (is_ext) begin
            yo9      = yo_raw[8:0];
            xo9      = xo_raw[8:0];
            code_off = yo_raw[13:9];
            flip_y   = attr[4] ^ yo_raw[14];
            flip_x   = attr[5] ^ yo_raw[15];
        end else begin
            yo9      = {off_q[3][0], off_q[1]};
            xo9      = {off_q[2][0], off_q[0]};
            code_off = 5'd0;
            flip_y   = attr[4];
            flip_x   = attr[5];
        end
    end

    // The x fold only depends on the low nine bits of the sum.
    assign x_low    = x9 + xo9;
    assign ysum     = {2'b00, y9} + {{2{yo9[8]}}, yo9};
    assign y_fin    = (short_screen_reg && !ysum[10] && (ysum != 11'd0))
                      ? {1'b0, ysum[7:0]} : ysum[8:0];
    assign code_sum = {1'b0, spr_q[2], spr_q[3]} + 17'(code_off);

    // Result register.
    logic        m_valid_reg;
    logic [16:0] tile_code_reg;
    logic [1:0]  palette_reg;
    logic        mirror_x_reg, mirror_y_reg;
    logic [9:0]  screen_x_reg;
    logic [8:0]  screen_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            tile_code_reg <= code_sum;
            palette_reg   <= attr[1:0];
            mirror_x_reg  <= flip_x;
            mirror_y_reg  <= flip_y;
            screen_x_reg  <= {x_low[8] & x_low[7], x_low};
            screen_y_reg  <= y_fin;
        end
    end

    assign status.is_ext   = is_ext;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_tile_code = tile_code_reg;
    assign m_palette   = palette_reg;
    assign m_mirror_x  = mirror_x_reg;
    assign m_mirror_y  = mirror_y_reg;
    assign m_screen_x  = signed'(screen_x_reg);
    assign m_screen_y  = signed'(screen_y_reg);

endmodule

>>> src/sprite_attribute_resolver.sv
// ============================================================================
// sprite_attribute_resolver
// Resolves a sprite's code, palette, flips and wrapped screen position from
// its attribute record, index byte, offset entry and extended entry.
// ============================================================================
// Usage:
// The request channel (s_*) carries an operation, a byte address and a write
// byte. Operations 0 to 3 store one byte into the sprite, index, offset or
// extended memory; they give no result. Operations 5 to 7 are taken and
// dropped. Operation 4 resolves a sprite and gives one result on the m_*
// channel.
// A resolve runs from acceptance through the three-stage modulo unit (used
// once, or twice when the offset entry points into the extended table) and
// the chain of dependent memory reads to the result register; requests are
// taken one at a time, so a new request is accepted in the cycle after the
// previous result is loaded, even while that result still waits on the m_*
// side.
// When the receiver stalls, the result is held and the controller waits
// with a finished resolve until the result register frees up.
// Reset clears the control state and short_screen; memory contents are
// undefined until written. short_screen is written through cfg_wr_en.
// ============================================================================
module sprite_attribute_resolver #(
    parameter int SPRITE_COUNT     = sar_pkg::SPRITE_COUNT_DEF,
    parameter int EXTENDED_ENTRIES = sar_pkg::EXTENDED_ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_op,
    input  logic [15:0]       s_address,
    input  logic [7:0]        s_write_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [16:0]       m_tile_code,
    output logic [1:0]        m_palette,
    output logic              m_mirror_x,
    output logic              m_mirror_y,
    output logic signed [9:0] m_screen_x,
    output logic signed [8:0] m_screen_y
);

    sar_pkg::sar_cmd_t    cmd;
    sar_pkg::sar_status_t status;

    // Request sequencing.
    sar_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_op   (s_op),
        .s_ready(s_ready),
        .status (status),
        .cmd    (cmd)
    );

    // Memories, arithmetic and result register.
    sar_dp #(
        .SPRITE_COUNT    (SPRITE_COUNT),
        .EXTENDED_ENTRIES(EXTENDED_ENTRIES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_op        (s_op),
        .s_address   (s_address),
        .s_write_byte(s_write_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_tile_code (m_tile_code),
        .m_palette   (m_palette),
        .m_mirror_x  (m_mirror_x),
        .m_mirror_y  (m_mirror_y),
        .m_screen_x  (m_screen_x),
        .m_screen_y  (m_screen_y)
    );

endmodule
